// File: sv/gfe_pkg.sv
// Shared constants, types and the exp table of the formant envelope block.
package gfe_pkg;

  // Block sizing
  localparam int FFT_SIZE    = 1024;
  localparam int EXP_DEPTH   = 1024;
  localparam int STORE_DEPTH = FFT_SIZE / 2 + 1;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ETAB_AW     = $clog2(EXP_DEPTH);
  // Every index from EXP_DEPTH/4 up lies past x^2 = 11 and reads zero
  localparam int ETAB_LIVE   = EXP_DEPTH / 4;
  localparam int ETAB_LAW    = $clog2(ETAB_LIVE);

  // exp(-1) in Q32
  localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;

  // Q2.14 constants
  localparam logic [15:0] BASELINE_Q14 = 16'd2458;
  localparam logic [15:0] CLAMP_Q14    = 16'd40960;
  localparam logic [15:0] TINY_Q14     = 16'd163;
  // 2 * 1.8 * 5 scaled: 2 * 147456
  localparam logic [18:0] READ_MUL     = 19'd294912;

  // Shared divider sizing
  localparam int REM_W  = 41;
  localparam int DEN_W  = 22;
  localparam int QW     = 17;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] BUILD_LAST_BIT = 5'd9;
  localparam logic [CNT_W-1:0] READ_LAST_BIT  = 5'd16;

  // Register map
  typedef enum logic [2:0] {
    REG_F1_HZ  = 3'd0,
    REG_F1_BW  = 3'd1,
    REG_F2_HZ  = 3'd2,
    REG_F2_BW  = 3'd3,
    REG_F3_HZ  = 3'd4,
    REG_F3_BW  = 3'd5,
    REG_INTENS = 3'd6,
    REG_HZ_BIN = 3'd7
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_BUILD = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREQ,
    ST_PREP,
    ST_CHK,
    ST_DIV,
    ST_ACC,
    ST_STORE,
    ST_RCHK,
    ST_RDIV,
    ST_RFIN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic freq;
    logic prep;
    logic bchk;
    logic rchk;
    logic div_step;
    logic acc;
    logic store;
    logic rfin;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_read;
    logic in_oob;
    logic bovf;
    logic rdone;
    logic div_last;
    logic k_last;
    logic out_free;
  } sts_t;

  // exp(-x^2) in Q2.14 for x = 16*i/EXP_DEPTH, the live lower quarter only;
  // integer series on the fraction of x^2, times exp(-1) per whole unit
  typedef logic [15:0] etab_t [ETAB_LIVE];

  function automatic etab_t build_etab();
    etab_t           tab;
    longint unsigned lim;
    longint unsigned num;
    longint unsigned y;
    longint unsigned n;
    longint unsigned f;
    longint unsigned tk;
    longint unsigned v;
    longint          acc;
    lim = 64'(11) * 64'(EXP_DEPTH) * 64'(EXP_DEPTH);
    for (int i = 0; i < ETAB_LIVE; i++) begin
      num = 64'(i) * 64'(i) * 64'd256;
      if (num >= lim) begin
        tab[i] = 16'd0;
      end else begin
        // x^2 in Q32; EXP_DEPTH squared is a power of two
        y   = (num << 32) >> (2 * ETAB_AW);
        n   = y >> 32;
        f   = y & 64'hFFFF_FFFF;
        acc = 64'sd1 <<< 32;
        tk  = 64'd1 << 32;
        for (int k = 1; k <= 24; k++) begin
          tk = ((tk * f) >> 32) / 64'(k);
          if (k[0]) begin
            acc = acc - $signed(tk);
          end else begin
            acc = acc + $signed(tk);
          end
        end
        v = $unsigned(acc);
        for (longint unsigned j = 0; j < n; j++) begin
          v = (v * EXP_M1_Q32 + 64'h8000_0000) >> 32;
        end
        tab[i] = 16'((v + 64'h2_0000) >> 18);
      end
    end
    return tab;
  endfunction

  localparam etab_t ETAB = build_etab();

endpackage

// File: sv/gfe_ram.sv
// Generic simple dual-port RAM with registered read.
module gfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gfe_datapath.sv
// Datapath: config registers, bandwidth and distance, shared divider, store.
module gfe_datapath import gfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i,
  input  logic        opcode_i,
  input  logic [9:0]  bin_index_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [15:0] gain_value_o,
  output logic [9:0]  bin_echo_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  // Configuration registers
  logic [14:0] f_hz_q [3];
  logic [11:0] f_bw_q [3];
  logic [8:0]  intens_q;
  logic [21:0] hz_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_hz_q[0] <= 15'd700;
      f_bw_q[0] <= 12'd90;
      f_hz_q[1] <= 15'd1220;
      f_bw_q[1] <= 12'd110;
      f_hz_q[2] <= 15'd2600;
      f_bw_q[2] <= 12'd170;
      intens_q  <= 9'd128;
      hz_bin_q  <= 22'd11025;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_F1_HZ:  f_hz_q[0] <= cfg_data_i[14:0];
        REG_F1_BW:  f_bw_q[0] <= cfg_data_i[11:0];
        REG_F2_HZ:  f_hz_q[1] <= cfg_data_i[14:0];
        REG_F2_BW:  f_bw_q[1] <= cfg_data_i[11:0];
        REG_F3_HZ:  f_hz_q[2] <= cfg_data_i[14:0];
        REG_F3_BW:  f_bw_q[2] <= cfg_data_i[11:0];
        REG_INTENS: intens_q  <= cfg_data_i[8:0];
        REG_HZ_BIN: hz_bin_q  <= cfg_data_i;
      endcase
    end
  end

  // Item registers
  logic [9:0]  bin_q;
  logic [31:0] freq_q;
  logic [1:0]  k_q;
  logic [31:0] diff_q;
  logic [21:0] bw_q;
  logic        skip_q;
  logic [16:0] sum_q;
  logic [15:0] peak_q;
  logic [15:0] res_q;

  assign sts_o.in_read = (opcode_e'(opcode_i) == OP_READ);
  assign sts_o.in_oob  = ({1'b0, bin_index_i} >= 11'(STORE_DEPTH));
  assign sts_o.k_last  = (k_q == 2'd2);

  // Bandwidth: width * (1024 - 3*intensity), floored at 1 Hz (Q9)
  logic [11:0] intens3;
  logic [11:0] scale;
  logic        scale_pos;
  logic [21:0] bw_prod;
  logic [21:0] bw_d;
  logic [31:0] centre_q8;
  logic [31:0] diff_d;

  assign intens3   = 12'(intens_q) * 12'd3;
  assign scale     = 12'd1024 - intens3;
  assign scale_pos = !scale[11] && (scale != 12'd0);
  assign bw_prod   = 22'(f_bw_q[k_q]) * 22'(scale[10:0]);
  assign bw_d      = (!scale_pos || bw_prod < 22'd512) ? 22'd512 : bw_prod;
  assign centre_q8 = {9'd0, f_hz_q[k_q], 8'd0};
  assign diff_d    = (freq_q >= centre_q8) ? freq_q - centre_q8 : centre_q8 - freq_q;

  // Term is zero when diff*128/bw >= 1024
  assign sts_o.bovf = (diff_q >= {7'd0, bw_q, 3'd0});

  // Read scaling: (2*raw*147456 + 5p) / (10p)
  logic [15:0] raw;
  logic [34:0] rd_num;
  logic [19:0] rd_den;
  logic        rd_ovf;
  logic        rd_tiny;

  assign rd_num  = 35'(raw) * 35'(READ_MUL) + 35'(19'(peak_q) * 19'd5);
  assign rd_den  = 20'(peak_q) * 20'd10;
  assign rd_ovf  = (41'(rd_num) >= (41'(rd_den) << QW));
  assign rd_tiny = (peak_q <= TINY_Q14);
  assign sts_o.rdone = rd_tiny || rd_ovf;

  // Shared restoring divider, one quotient bit per cycle
  logic [REM_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    quo_q;
  logic [REM_W-1:0] den_shift;
  logic             fits;

  assign den_shift      = REM_W'(den_q) << cnt_q;
  assign fits           = (rem_q >= den_shift);
  assign sts_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bchk) begin
      rem_q <= REM_W'({diff_q, 7'd0});
      den_q <= bw_q;
      cnt_q <= BUILD_LAST_BIT;
      quo_q <= '0;
    end else if (cmd_i.rchk) begin
      rem_q <= REM_W'(rd_num);
      den_q <= DEN_W'(rd_den);
      cnt_q <= READ_LAST_BIT;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= rem_q - den_shift;
      end
      quo_q <= {quo_q[QW-2:0], fits};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Table lookup for the finished distance; the upper indexes all read zero
  logic [ETAB_AW+9:0] idx_prod;
  logic [ETAB_AW-1:0] etab_idx;
  logic [15:0]        term;

  assign idx_prod = (ETAB_AW+10)'(quo_q[9:0]) * (ETAB_AW+10)'(EXP_DEPTH);
  assign etab_idx = idx_prod[ETAB_AW+9:10];
  assign term     = (skip_q || etab_idx >= ETAB_AW'(ETAB_LIVE)) ? 16'd0
                                                               : ETAB[etab_idx[ETAB_LAW-1:0]];

  // Stored value: baseline added, clamped
  logic [17:0] gain_sum;
  logic [15:0] gain_st;

  assign gain_sum = 18'(sum_q) + 18'(BASELINE_Q14);
  assign gain_st  = (gain_sum > 18'(CLAMP_Q14)) ? CLAMP_Q14 : gain_sum[15:0];

  // Item and accumulation registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bin_q <= bin_index_i;
      res_q <= 16'd0;
    end
    if (cmd_i.freq) begin
      freq_q <= 32'(bin_q) * 32'(hz_bin_q);
      k_q    <= 2'd0;
      sum_q  <= 17'd0;
    end
    if (cmd_i.prep) begin
      diff_q <= diff_d;
      bw_q   <= bw_d;
    end
    if (cmd_i.bchk) begin
      skip_q <= sts_o.bovf;
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + 17'(term);
      k_q   <= k_q + 2'd1;
    end
    if (cmd_i.rchk) begin
      if (rd_tiny) begin
        res_q <= raw;
      end else if (rd_ovf) begin
        res_q <= 16'hFFFF;
      end
    end
    if (cmd_i.rfin) begin
      res_q <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
    end
  end

  // Running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= 16'd0;
    end else if (cmd_i.store && gain_st > peak_q) begin
      peak_q <= gain_st;
    end
  end

  // Gain store
  gfe_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (bin_q[STORE_AW-1:0]),
    .wdata_i (gain_st),
    .re_i    (cmd_i.accept),
    .raddr_i (bin_index_i[STORE_AW-1:0]),
    .rdata_o (raw)
  );

  // Output register
  logic        out_valid_q;
  logic [15:0] gain_q;
  logic [9:0]  echo_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      gain_q <= res_q;
      echo_q <= bin_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gain_value_o = gain_q;
  assign bin_echo_o   = echo_q;

endmodule

// File: sv/gfe_ctrl.sv
// Controller: sequences build and read items over the datapath.
module gfe_ctrl import gfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_read) begin
            state_d = sts_i.in_oob ? ST_DONE : ST_RCHK;
          end else if (!sts_i.in_oob) begin
            state_d = ST_FREQ;
          end
        end
      end
      ST_FREQ: begin
        cmd_o.freq = 1'b1;
        state_d    = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.bchk = 1'b1;
        state_d    = sts_i.bovf ? ST_ACC : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.k_last ? ST_STORE : ST_PREP;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_RCHK: begin
        cmd_o.rchk = 1'b1;
        state_d    = sts_i.rdone ? ST_DONE : ST_RDIV;
      end
      ST_RDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RFIN;
        end
      end
      ST_RFIN: begin
        cmd_o.rfin = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/gaussian_formant_envelope.sv
// Gaussian formant spectral envelope: builds, stores and reads per-bin gains.
// A build transfer (opcode 0) computes one bin's gain as the sum of three
// Gaussian formant peaks plus a 0.15 baseline, clamped at 2.5, stores it and
// updates the running maximum; it gives no result, and a bin above
// FFT_SIZE/2 is dropped. A read transfer (opcode 1) returns the stored gain
// scaled by 1.8/max in Q2.14 with the bin echoed; out-of-range bins read 0.
// Bins must be built before they are read. One item is in flight at a time.
// Each formant distance goes through one shared divider at one quotient bit
// per cycle; a formant far from the bin skips the divider. A read divides in
// 17 steps; it skips the divider and returns the stored gain unscaled when the
// maximum is tiny, or 0xFFFF when the result saturates. A finished result
// waits in the output register while the next item is taken.
module gaussian_formant_envelope import gfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [9:0]  bin_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] gain_value_o,
  output logic [9:0]  bin_echo_o
);

  cmd_t cmd;
  sts_t sts;

  gfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gfe_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .bin_index_i  (bin_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .gain_value_o (gain_value_o),
    .bin_echo_o   (bin_echo_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
